// ===== hw/rtl/zwc_pkg.sv =====
// Shared codes, field widths and checksum helpers for the zlib wrapper checker.
package zwc_pkg;

    // Operation codes carried on the input tuser
    localparam logic [2:0] OP_STREAM    = 3'd0;
    localparam logic [2:0] OP_DECOMP    = 3'd1;
    localparam logic [2:0] OP_FINISH    = 3'd2;
    localparam logic [2:0] OP_END       = 3'd3;
    localparam logic [2:0] OP_INFL_ERR  = 3'd4;

    // Reported stage codes
    localparam logic [2:0] STAGE_HEADER = 3'd0;
    localparam logic [2:0] STAGE_DICT   = 3'd1;
    localparam logic [2:0] STAGE_DATA   = 3'd2;
    localparam logic [2:0] STAGE_TRAIL  = 3'd3;
    localparam logic [2:0] STAGE_DONE   = 3'd4;
    localparam logic [2:0] STAGE_ERROR  = 3'd5;

    // Fault codes
    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_HDR_CHECK = 3'd1;
    localparam logic [2:0] FAULT_METHOD    = 3'd2;
    localparam logic [2:0] FAULT_WINDOW    = 3'd3;
    localparam logic [2:0] FAULT_CHECKSUM  = 3'd4;
    localparam logic [2:0] FAULT_INCOMPLETE = 3'd5;
    localparam logic [2:0] FAULT_INFLATER  = 3'd6;

    // Header fields
    localparam logic [3:0] CM_DEFLATE = 4'd8;
    localparam logic [3:0] CINFO_MAX  = 4'd7;
    localparam int         FDICT_BIT  = 5;

    // Adler-32
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [31:0] ADLER_INIT = 32'd1;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;

    // One Adler-32 byte step; both halves of sum are already below the modulus
    function automatic logic [31:0] adler_step(input logic [31:0] sum, input logic [7:0] b);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, sum[15:0]} + {9'd0, b};
        if (s1 >= ADLER_MOD)
        begin
            s1 = s1 - ADLER_MOD;
        end
        s2 = {1'b0, sum[31:16]} + s1;
        if (s2 >= ADLER_MOD)
        begin
            s2 = s2 - ADLER_MOD;
        end
        return {s2[15:0], s1[15:0]};
    endfunction

    // True when a 16-bit word is a multiple of 31 (2**5 is 1 mod 31: fold 5-bit digits)
    function automatic logic is_mult31(input logic [15:0] x);
        logic [6:0] f1;
        logic [5:0] f2;
        f1 = {2'b0, x[4:0]} + {2'b0, x[9:5]} + {2'b0, x[14:10]} + {6'b0, x[15]};
        f2 = {1'b0, f1[4:0]} + {4'b0, f1[6:5]};
        return (f2 == 6'd0) || (f2 == 6'd31);
    endfunction

endpackage

// ===== hw/rtl/zlib_wrapper_checker.sv =====
// Top level of the zlib wrapper checker: header, dictionary, pass-through and trailer check.
//
//  channel  | dir | signals                    | content
//  ---------+-----+----------------------------+--------------------------------------------
//  s_axis   | in  | tvalid tready tdata tuser  | tdata[7:0] data_byte, tuser[2:0] operation
//  m_axis   | out | tvalid tready tdata        | one result item per input item (see port)
//
// Every item passes through the input register and then the result register;
// one item is accepted per cycle when m_axis is not stalled.
// The Adler-32 step (add, conditional subtract, twice) sets the cycle time.
// rst_n clears the wrapper state to "first header byte expected" and empties both stages.
// A stall on m_axis holds the result register and then the input register; back-pressure
// reaches s_axis_tready combinationally.
module zlib_wrapper_checker
    import zwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [2:0] operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] consumed, [1] forward_valid,
                                                  // [9:2] forward_byte, [10] out_valid,
                                                  // [18:11] out_byte, [21:19] stage,
                                                  // [24:22] fault, [26:25] level_seen,
                                                  // [29:27] window_exponent, [31:30] zero
);

    typedef enum logic [3:0] {
        PH_CMF   = 4'd0,
        PH_FLG   = 4'd1,
        PH_ID0   = 4'd2,
        PH_ID1   = 4'd3,
        PH_ID2   = 4'd4,
        PH_ID3   = 4'd5,
        PH_DICT  = 4'd6,
        PH_DATA  = 4'd7,
        PH_TRL0  = 4'd8,
        PH_TRL1  = 4'd9,
        PH_TRL2  = 4'd10,
        PH_TRL3  = 4'd11,
        PH_DONE  = 4'd12,
        PH_ERROR = 4'd13
    } phase_t;

    // Input register
    logic                 in_valid_reg;
    logic [2:0]           op_reg;
    logic [7:0]           byte_reg;

    // Result register
    logic                 res_valid_reg;
    logic [OUT_DATA_W-1:0] res_data_reg;
    logic [OUT_DATA_W-1:0] res_data_next;

    // Wrapper state
    phase_t      phase_reg,       phase_next;
    logic [7:0]  cmf_reg,         cmf_next;
    logic [31:0] dict_id_reg,     dict_id_next;
    logic [31:0] adler_reg,       adler_next;
    logic [23:0] trail_reg,       trail_next;
    logic [1:0]  level_reg,       level_next;
    logic [2:0]  window_reg,      window_next;
    logic [2:0]  fault_reg,       fault_next;

    logic        advance;
    logic        consumed;
    logic        fwd_valid;
    logic        dec_valid;
    logic [2:0]  stage;
    logic [31:0] adler_sum;
    logic [31:0] dict_word;
    logic [31:0] trail_word;
    logic        hdr_ok;

    // Move the held item into the result register when that register is free or drains
    assign advance       = in_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = res_data_reg;

    assign adler_sum  = adler_step(adler_reg, byte_reg);
    assign dict_word  = {dict_id_reg[23:0], byte_reg};
    assign trail_word = {trail_reg, byte_reg};
    assign hdr_ok     = is_mult31({cmf_reg, byte_reg});

    always_comb
    begin
        phase_next   = phase_reg;
        cmf_next     = cmf_reg;
        dict_id_next = dict_id_reg;
        adler_next   = adler_reg;
        trail_next   = trail_reg;
        level_next   = level_reg;
        window_next  = window_reg;
        fault_next   = fault_reg;
        consumed     = 1'b0;
        fwd_valid    = 1'b0;
        dec_valid    = 1'b0;

        unique case (op_reg)
            OP_STREAM:
            begin
                unique case (phase_reg)
                    PH_CMF:
                    begin
                        cmf_next   = byte_reg;
                        phase_next = PH_FLG;
                        consumed   = 1'b1;
                    end
                    PH_FLG:
                    begin
                        // Checks in order; a failing byte is not consumed
                        priority if (!hdr_ok)
                        begin
                            fault_next = FAULT_HDR_CHECK;
                            phase_next = PH_ERROR;
                        end
                        else if (cmf_reg[3:0] != CM_DEFLATE)
                        begin
                            fault_next = FAULT_METHOD;
                            phase_next = PH_ERROR;
                        end
                        else if (cmf_reg[7:4] > CINFO_MAX)
                        begin
                            fault_next = FAULT_WINDOW;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            window_next = cmf_reg[6:4];
                            level_next  = byte_reg[7:6];
                            adler_next  = ADLER_INIT;
                            phase_next  = byte_reg[FDICT_BIT] ? PH_ID0 : PH_DATA;
                            consumed    = 1'b1;
                        end
                    end
                    PH_ID0, PH_ID1, PH_ID2:
                    begin
                        dict_id_next = dict_word;
                        phase_next   = phase_t'(phase_reg + 4'd1);
                        consumed     = 1'b1;
                    end
                    PH_ID3:
                    begin
                        // Id equal to the initial sum means an empty dictionary
                        dict_id_next = dict_word;
                        phase_next   = (adler_reg == dict_word) ? PH_DATA : PH_DICT;
                        adler_next   = ADLER_INIT;
                        consumed     = 1'b1;
                    end
                    PH_DICT:
                    begin
                        consumed = 1'b1;
                        if (adler_sum == dict_id_reg)
                        begin
                            adler_next = ADLER_INIT;
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            adler_next = adler_sum;
                        end
                    end
                    PH_DATA:
                    begin
                        consumed  = 1'b1;
                        fwd_valid = 1'b1;
                    end
                    PH_TRL0, PH_TRL1, PH_TRL2:
                    begin
                        trail_next = trail_word[23:0];
                        phase_next = phase_t'(phase_reg + 4'd1);
                        consumed   = 1'b1;
                    end
                    PH_TRL3:
                    begin
                        if (trail_word != adler_reg)
                        begin
                            fault_next = FAULT_CHECKSUM;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            consumed   = 1'b1;
                        end
                    end
                    default:
                    begin
                        // done, error: drop the byte
                    end
                endcase
            end
            OP_DECOMP:
            begin
                if (phase_reg == PH_DATA)
                begin
                    adler_next = adler_sum;
                    dec_valid  = 1'b1;
                end
            end
            OP_FINISH:
            begin
                if (phase_reg == PH_DATA)
                begin
                    trail_next = '0;
                    phase_next = PH_TRL0;
                end
            end
            OP_END:
            begin
                if (phase_reg != PH_DONE && phase_reg != PH_ERROR)
                begin
                    fault_next = FAULT_INCOMPLETE;
                    phase_next = PH_ERROR;
                end
            end
            OP_INFL_ERR:
            begin
                if (phase_reg != PH_ERROR)
                begin
                    fault_next = FAULT_INFLATER;
                    phase_next = PH_ERROR;
                end
            end
            default:
            begin
                // unused operation codes: ignore
            end
        endcase
    end

    // Stage reported after the update
    always_comb
    begin
        unique case (phase_next)
            PH_CMF, PH_FLG, PH_ID0, PH_ID1, PH_ID2, PH_ID3: stage = STAGE_HEADER;
            PH_DICT:                                        stage = STAGE_DICT;
            PH_DATA:                                        stage = STAGE_DATA;
            PH_TRL0, PH_TRL1, PH_TRL2, PH_TRL3:             stage = STAGE_TRAIL;
            PH_DONE:                                        stage = STAGE_DONE;
            default:                                        stage = STAGE_ERROR;
        endcase
    end

    assign res_data_next = {2'b00,
                            window_next,
                            level_next,
                            fault_next,
                            stage,
                            dec_valid ? byte_reg : 8'd0,
                            dec_valid,
                            fwd_valid ? byte_reg : 8'd0,
                            fwd_valid,
                            consumed};

    // Input register: load on accept, empty when the item advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg   <= s_axis_tuser;
            byte_reg <= s_axis_tdata;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_data_reg <= res_data_next;
        end
    end

    // Wrapper state: advance only with an item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CMF;
            cmf_reg     <= '0;
            dict_id_reg <= '0;
            adler_reg   <= ADLER_INIT;
            trail_reg   <= '0;
            level_reg   <= '0;
            window_reg  <= '0;
            fault_reg   <= FAULT_NONE;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            cmf_reg     <= cmf_next;
            dict_id_reg <= dict_id_next;
            adler_reg   <= adler_next;
            trail_reg   <= trail_next;
            level_reg   <= level_next;
            window_reg  <= window_next;
            fault_reg   <= fault_next;
        end
    end

endmodule

// ===== tb/zwc_result_checker.sv =====
// Result checker for the zlib wrapper checker: follows the container state and checks each result.
`timescale 1ns / 100ps

module zwc_result_checker
    import zwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [2:0] operation
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] consumed, [1] forward_valid,
                                                  // [9:2] forward_byte, [10] out_valid,
                                                  // [18:11] out_byte, [21:19] stage,
                                                  // [24:22] fault, [26:25] level_seen,
                                                  // [29:27] window_exponent, [31:30] zero
    output int unsigned           miscompares,
    output int unsigned           awaited
);

    // Wrapper position, one code per header, id and trailer byte
    localparam logic [3:0] PH_CMF         = 4'd0;
    localparam logic [3:0] PH_FLG         = 4'd1;
    localparam logic [3:0] PH_ID_FIRST    = 4'd2;
    localparam logic [3:0] PH_ID_LAST     = 4'd5;
    localparam logic [3:0] PH_DICT        = 4'd6;
    localparam logic [3:0] PH_DATA        = 4'd7;
    localparam logic [3:0] PH_TRAIL_FIRST = 4'd8;
    localparam logic [3:0] PH_TRAIL_LAST  = 4'd11;
    localparam logic [3:0] PH_DONE        = 4'd12;
    localparam logic [3:0] PH_ERROR       = 4'd13;

    localparam int HDR_DIVISOR = 31;

    typedef struct packed {
        logic [1:0] spare;
        logic [2:0] window;
        logic [1:0] level;
        logic [2:0] fault;
        logic [2:0] stage;
        logic [7:0] out_byte;
        logic       out_valid;
        logic [7:0] fwd_byte;
        logic       fwd_valid;
        logic       consumed;
    } wrapper_result_t;

    logic [3:0]  phase;
    logic [7:0]  cmf_byte;
    logic [31:0] dict_id;
    logic [31:0] adler;
    logic [23:0] trail_bytes;
    logic [1:0]  level_q;
    logic [2:0]  window_q;
    logic [2:0]  fault_q;

    wrapper_result_t expected_results[$];
    wrapper_result_t want;
    wrapper_result_t got;
    wrapper_result_t pred;
    string           diffs;
    int unsigned     failures;
    int unsigned     result_index;

    assign miscompares = failures;

    function automatic logic [31:0] adler_add(input logic [31:0] sum, input logic [7:0] b);
        int unsigned lo;
        int unsigned hi;
        lo = (sum[15:0] + b) % ADLER_MOD;
        hi = (sum[31:16] + lo) % ADLER_MOD;
        return {hi[15:0], lo[15:0]};
    endfunction

    function automatic string describe(input wrapper_result_t r);
        return $sformatf({"consumed=%0d fwd=%0d/%02h out=%0d/%02h stage=%0d fault=%0d",
                          " level=%0d window=%0d spare=%0d"},
                         r.consumed, r.fwd_valid, r.fwd_byte, r.out_valid, r.out_byte,
                         r.stage, r.fault, r.level, r.window, r.spare);
    endfunction

    // Errors stick: the first fault wins
    task automatic raise_fault(input logic [2:0] code);
        if (phase != PH_ERROR)
        begin
            fault_q = code;
            phase   = PH_ERROR;
        end
    endtask

    task automatic predict_item(input logic [2:0] op, input logic [7:0] b,
                                output wrapper_result_t r);
        r = '0;
        case (op)
            OP_STREAM:
            begin
                if (phase == PH_CMF)
                begin
                    cmf_byte   = b;
                    phase      = PH_FLG;
                    r.consumed = 1'b1;
                end
                else if (phase == PH_FLG)
                begin
                    if ({cmf_byte, b} % HDR_DIVISOR != 0)
                    begin
                        raise_fault(FAULT_HDR_CHECK);
                    end
                    else if (cmf_byte[3:0] != CM_DEFLATE)
                    begin
                        raise_fault(FAULT_METHOD);
                    end
                    else if (cmf_byte[7:4] > CINFO_MAX)
                    begin
                        raise_fault(FAULT_WINDOW);
                    end
                    else
                    begin
                        window_q   = cmf_byte[6:4];
                        level_q    = b[7:6];
                        adler      = ADLER_INIT;
                        phase      = b[FDICT_BIT] ? PH_ID_FIRST : PH_DATA;
                        r.consumed = 1'b1;
                    end
                end
                else if (phase >= PH_ID_FIRST && phase <= PH_ID_LAST)
                begin
                    dict_id    = {dict_id[23:0], b};
                    r.consumed = 1'b1;
                    if (phase == PH_ID_LAST)
                    begin
                        // an id of one means an empty dictionary
                        phase = (adler == dict_id) ? PH_DATA : PH_DICT;
                        adler = ADLER_INIT;
                    end
                    else
                    begin
                        phase = phase + 4'd1;
                    end
                end
                else if (phase == PH_DICT)
                begin
                    adler      = adler_add(adler, b);
                    r.consumed = 1'b1;
                    if (adler == dict_id)
                    begin
                        adler = ADLER_INIT;
                        phase = PH_DATA;
                    end
                end
                else if (phase == PH_DATA)
                begin
                    r.consumed  = 1'b1;
                    r.fwd_valid = 1'b1;
                    r.fwd_byte  = b;
                end
                else if (phase >= PH_TRAIL_FIRST && phase <= PH_TRAIL_LAST)
                begin
                    if (phase == PH_TRAIL_LAST)
                    begin
                        if ({trail_bytes, b} != adler)
                        begin
                            raise_fault(FAULT_CHECKSUM);
                        end
                        else
                        begin
                            phase      = PH_DONE;
                            r.consumed = 1'b1;
                        end
                    end
                    else
                    begin
                        trail_bytes = {trail_bytes[15:0], b};
                        phase       = phase + 4'd1;
                        r.consumed  = 1'b1;
                    end
                end
            end
            OP_DECOMP:
            begin
                if (phase == PH_DATA)
                begin
                    adler       = adler_add(adler, b);
                    r.out_valid = 1'b1;
                    r.out_byte  = b;
                end
            end
            OP_FINISH:
            begin
                if (phase == PH_DATA)
                begin
                    trail_bytes = '0;
                    phase       = PH_TRAIL_FIRST;
                end
            end
            OP_END:
            begin
                if (phase != PH_DONE && phase != PH_ERROR)
                begin
                    raise_fault(FAULT_INCOMPLETE);
                end
            end
            OP_INFL_ERR:
            begin
                raise_fault(FAULT_INFLATER);
            end
            default:
            begin
            end
        endcase

        if (phase <= PH_ID_LAST)
        begin
            r.stage = STAGE_HEADER;
        end
        else if (phase == PH_DICT)
        begin
            r.stage = STAGE_DICT;
        end
        else if (phase == PH_DATA)
        begin
            r.stage = STAGE_DATA;
        end
        else if (phase >= PH_TRAIL_FIRST && phase <= PH_TRAIL_LAST)
        begin
            r.stage = STAGE_TRAIL;
        end
        else if (phase == PH_DONE)
        begin
            r.stage = STAGE_DONE;
        end
        else
        begin
            r.stage = STAGE_ERROR;
        end
        r.fault  = fault_q;
        r.level  = level_q;
        r.window = window_q;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase        = PH_CMF;
            cmf_byte     = '0;
            dict_id      = '0;
            adler        = ADLER_INIT;
            trail_bytes  = '0;
            level_q      = '0;
            window_q     = '0;
            fault_q      = FAULT_NONE;
            failures     = 0;
            result_index = 0;
            expected_results.delete();
            awaited     <= 0;
        end
        else
        begin
            // results leave before this edge's item enters, so compare first
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("result %0d arrived with nothing expected: %s",
                                 result_index, describe(got));
                    end
                end
                else
                begin
                    want  = expected_results.pop_front();
                    diffs = "";
                    if (got.consumed != want.consumed)   diffs = {diffs, " consumed"};
                    if (got.fwd_valid != want.fwd_valid) diffs = {diffs, " forward_valid"};
                    if (got.fwd_byte != want.fwd_byte)   diffs = {diffs, " forward_byte"};
                    if (got.out_valid != want.out_valid) diffs = {diffs, " out_valid"};
                    if (got.out_byte != want.out_byte)   diffs = {diffs, " out_byte"};
                    if (got.stage != want.stage)         diffs = {diffs, " stage"};
                    if (got.fault != want.fault)         diffs = {diffs, " fault"};
                    if (got.level != want.level)         diffs = {diffs, " level_seen"};
                    if (got.window != want.window)       diffs = {diffs, " window_exponent"};
                    if (got.spare != want.spare)         diffs = {diffs, " spare"};
                    if (diffs != "")
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("result %0d differs in%s: expected %s, got %s",
                                     result_index, diffs, describe(want), describe(got));
                        end
                    end
                end
                result_index++;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_item(s_axis_tuser, s_axis_tdata, pred);
                expected_results.push_back(pred);
            end

            awaited <= expected_results.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the zlib wrapper checker: drives one zlib stream and gives the verdict.
`timescale 1ns / 100ps

module testbench;
    import zwc_pkg::*;

    // Codes the block must ignore
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int          DATA_ITEMS  = 1000;
    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;   // [2:0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // result fields, see the block's port list
    int unsigned           miscompares;
    int unsigned           awaited;
    int unsigned           cycles        = 0;

    // High while both sides run without idling
    logic steady = 1'b0;

    zlib_wrapper_checker uut (.*);

    zwc_result_checker container_check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the result side in about one cycle of five, except in the steady stretch
    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 20);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("zlib_wrapper_checker regression: fail");
            $finish;
        end
    end

    // Bias toward 0xff so the Adler-32 sums wrap the modulus often
    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            return 8'hff;
        end
        if (pick < 35)
        begin
            return 8'h00;
        end
        return 8'($urandom_range(255));
    endfunction

    // Hand one item to the block. Call at a rising edge; returns at the edge that takes it.
    // Valid stays high after the handshake so back-to-back items need no second assignment.
    task automatic push_item(input logic [2:0] op, input logic [7:0] b);
        logic ready_seen;
        while (!steady && $urandom_range(99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do
        begin
            // ready is settled mid-cycle; it decides the handshake at the next edge
            @(negedge clk);
            ready_seen = s_axis_tready;
            @(posedge clk);
        end while (!ready_seen);
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end while (awaited != 0);
    endtask

    initial
    begin
        logic [7:0]  cmf;
        logic [7:0]  flg;
        logic [3:0]  method;
        logic [3:0]  cinfo;
        logic [7:0]  b;
        logic [31:0] dict_sum;
        logic [31:0] data_sum;
        logic [7:0]  dict_bytes[$];
        int          header_kind;
        int          dict_kind;
        int          ending;
        int          n;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header stage: inflater traffic and spare codes leave it untouched
        push_item(OP_DECOMP, 8'hff);
        push_item(OP_FINISH, 8'h00);
        push_item(OP_SPARE_FIRST, 8'hff);
        push_item(OP_SPARE_LAST, 8'h00);

        // Pick the header: mostly good, sometimes one of the three header faults.
        // The block never leaves error, so a bad header turns the rest into ignored items.
        header_kind = $urandom_range(0, 9);
        cinfo  = (header_kind == 2) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
        method = CM_DEFLATE;
        if (header_kind == 1)
        begin
            method = 4'($urandom_range(0, 14));
            if (method >= CM_DEFLATE)
            begin
                method = method + 4'd1;
            end
        end
        cmf = {cinfo, method};

        // No dictionary, an empty one (id of one), or a short real one
        dict_kind = $urandom_range(0, 2);
        flg = '0;
        flg[7:6] = 2'($urandom_range(0, 3));
        flg[FDICT_BIT] = (dict_kind != 0);
        if (header_kind == 0)
        begin
            do
            begin
                flg[4:0] = 5'($urandom_range(0, 31));
            end while ({cmf, flg} % 31 == 0);
        end
        else
        begin
            flg[4:0] = 5'((31 - ({cmf, flg} % 31)) % 31);
        end
        push_item(OP_STREAM, cmf);
        push_item(OP_STREAM, flg);

        if (dict_kind != 0)
        begin
            n = (dict_kind == 1) ? 0 : $urandom_range(1, 6);
            dict_sum = ADLER_INIT;
            for (int i = 0; i < n; i++)
            begin
                b = rand_byte();
                dict_sum = adler_step(dict_sum, b);
                dict_bytes.push_back(b);
            end
            // Id goes out big-endian
            for (int k = 0; k < 4; k++)
            begin
                push_item(OP_STREAM, dict_sum[31 - 8 * k -: 8]);
            end
            foreach (dict_bytes[i])
            begin
                // inflater noise in the dictionary stage must be dropped
                if ($urandom_range(99) < 30)
                begin
                    push_item($urandom_range(0, 1) ? OP_DECOMP : OP_FINISH, rand_byte());
                end
                push_item(OP_STREAM, dict_bytes[i]);
            end
        end

        // Compressed data: forward stream bytes, pass decompressed bytes, sprinkle spare codes
        data_sum = ADLER_INIT;
        for (int i = 0; i < DATA_ITEMS; i++)
        begin
            steady <= (i >= 300 && i < 450);
            n = $urandom_range(99);
            if (n < 40)
            begin
                push_item(OP_STREAM, rand_byte());
            end
            else if (n < 90)
            begin
                b = rand_byte();
                data_sum = adler_step(data_sum, b);
                push_item(OP_DECOMP, b);
            end
            else
            begin
                push_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), rand_byte());
            end
            if (i == DATA_ITEMS / 2)
            begin
                wait_drained();
            end
        end
        steady <= 1'b0;

        // End the stream: clean trailer, corrupted trailer, early end, or inflater failure
        ending = $urandom_range(0, 9);
        if (ending == 8)
        begin
            push_item(OP_INFL_ERR, rand_byte());
        end
        else if (ending == 9)
        begin
            push_item(OP_END, rand_byte());
        end
        else
        begin
            push_item(OP_FINISH, rand_byte());
            // trailer stage ignores inflater traffic
            push_item(OP_DECOMP, rand_byte());
            push_item(OP_FINISH, rand_byte());
            if (ending == 6)
            begin
                data_sum = data_sum ^ (32'd1 << $urandom_range(0, 31));
            end
            for (int k = 0; k < 4 && !(ending == 7 && k == 2); k++)
            begin
                push_item(OP_STREAM, data_sum[31 - 8 * k -: 8]);
            end
            if (ending == 7)
            begin
                push_item(OP_END, rand_byte());
            end
        end

        // Done or error: stream bytes, end of input and inflater traffic are dropped,
        // but an inflater error still faults a finished stream
        push_item(OP_STREAM, rand_byte());
        push_item(OP_DECOMP, rand_byte());
        push_item(OP_FINISH, rand_byte());
        push_item(OP_END, rand_byte());
        push_item(OP_INFL_ERR, rand_byte());
        push_item(OP_END, rand_byte());
        push_item(OP_STREAM, rand_byte());

        wait_drained();
        // catch any stray result after the last one
        repeat (4) @(posedge clk);
        if (miscompares == 0)
        begin
            $display("zlib_wrapper_checker regression: pass");
        end
        else
        begin
            $display("zlib_wrapper_checker regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/zwc_pkg.sv
hw/rtl/zlib_wrapper_checker.sv
tb/zwc_result_checker.sv
tb/testbench.sv
